// File: rtl/stcm_pkg.sv
// Shared types and constants for the scalar-to-color map block.
// Depends on nothing; every other file of the block except stcm_ifs refers to it by scoped names.
package stcm_pkg;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_RANGE_LOW  = 2'd0,
      CSR_RANGE_HIGH = 2'd1,
      CSR_MAP_KIND   = 2'd2
   } csr_index_type;

   // Color map selection codes; any other code selects the fringe map.
   typedef enum logic [2:0] {
      MAP_RAINBOW   = 3'd0,
      MAP_JET       = 3'd1,
      MAP_COOLWARM  = 3'd2,
      MAP_GRAYSCALE = 3'd3,
      MAP_FRINGE    = 3'd4
   } map_kind_type;

   // How the second color stage builds its scaled channel values.
   typedef enum logic [1:0] {
      BLEND_SCALE,
      BLEND_COOL_LOW,
      BLEND_COOL_HIGH,
      BLEND_FRINGE
   } blend_type;

   // Saturation flags of the normalized fraction.
   typedef struct packed {
      logic zero;
      logic one;
   } clamp_type;

   // Three 8-bit channels; element 0 is red, 1 green, 2 blue.
   typedef logic [2:0][7:0] rgb_type;

   localparam int FRINGE_LEVELS = 16;

   // Cool-warm end points and segment slopes, per channel.
   localparam rgb_type COOL_BASE       = {8'd192, 8'd76, 8'd59};
   localparam rgb_type COOL_LOW_SLOPE  = {8'd63, 8'd179, 8'd196};
   localparam rgb_type COOL_HIGH_SLOPE = {8'd217, 8'd251, 8'd75};
   localparam logic [7:0] CHANNEL_FULL = 8'd255;

   // Fringe palette, from dark blue up to dark red.
   function automatic rgb_type fringe_rgb(input logic [3:0] level);
      rgb_type entry;
      case (level)
         4'd0:    entry = {8'd170, 8'd0,   8'd0};
         4'd1:    entry = {8'd255, 8'd0,   8'd0};
         4'd2:    entry = {8'd255, 8'd85,  8'd0};
         4'd3:    entry = {8'd255, 8'd170, 8'd0};
         4'd4:    entry = {8'd255, 8'd255, 8'd0};
         4'd5:    entry = {8'd170, 8'd255, 8'd0};
         4'd6:    entry = {8'd85,  8'd255, 8'd0};
         4'd7:    entry = {8'd0,   8'd255, 8'd0};
         4'd8:    entry = {8'd0,   8'd255, 8'd85};
         4'd9:    entry = {8'd0,   8'd255, 8'd170};
         4'd10:   entry = {8'd0,   8'd255, 8'd255};
         4'd11:   entry = {8'd0,   8'd200, 8'd255};
         4'd12:   entry = {8'd0,   8'd140, 8'd255};
         4'd13:   entry = {8'd0,   8'd80,  8'd255};
         4'd14:   entry = {8'd0,   8'd0,   8'd255};
         4'd15:   entry = {8'd0,   8'd0,   8'd170};
         default: entry = '0;
      endcase
      return entry;
   endfunction

endpackage

// File: rtl/stcm_ifs.sv
// Valid/ready stream interfaces for the sample input and the color output.
// Depends on nothing; used by the scalar_to_color_map top level.
interface stcm_sample_if #(
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

interface stcm_color_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// File: rtl/stcm_front.sv
// Front stage: compares the sample with the range and forms numerator and denominator.
// Depends on stcm_pkg for the saturation flag type.
module stcm_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [VALUE_BITS-1:0]   in_sample,
   input  logic [VALUE_BITS-1:0]   range_low,
   input  logic [VALUE_BITS-1:0]   range_high,
   output logic                    out_valid,
   input  logic                    out_ready,
   output stcm_pkg::clamp_type     out_clamp,
   output logic [VALUE_BITS-1:0]   out_num,
   output logic [VALUE_BITS-1:0]   out_den
);

   logic                  valid_ff;
   stcm_pkg::clamp_type   clamp_ff;
   stcm_pkg::clamp_type   clamp_in;
   logic [VALUE_BITS-1:0] num_ff;
   logic [VALUE_BITS-1:0] den_ff;
   logic [VALUE_BITS-1:0] sample_biased;
   logic [VALUE_BITS-1:0] low_biased;
   logic [VALUE_BITS-1:0] high_biased;
   logic                  advance;

   // The stage moves when it is empty or its content leaves.
   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   // Flipping the sign bit turns signed order into unsigned order.
   assign sample_biased = {~in_sample[VALUE_BITS-1], in_sample[VALUE_BITS-2:0]};
   assign low_biased    = {~range_low[VALUE_BITS-1], range_low[VALUE_BITS-2:0]};
   assign high_biased   = {~range_high[VALUE_BITS-1], range_high[VALUE_BITS-2:0]};

   // Samples at or below the low end give zero; a degenerate range or a sample
   // at or above the high end gives one.
   always_comb begin
      clamp_in.zero = (sample_biased <= low_biased);
      clamp_in.one  = !clamp_in.zero &&
                      ((high_biased <= low_biased) || (sample_biased >= high_biased));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance && in_valid) begin
         clamp_ff <= clamp_in;
         num_ff   <= sample_biased - low_biased;
         den_ff   <= high_biased - low_biased;
      end
   end

   assign out_valid = valid_ff;
   assign out_clamp = clamp_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule

// File: rtl/stcm_divider.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on stcm_pkg for the saturation flag type carried alongside.
module stcm_divider #(
   parameter int VALUE_BITS    = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  stcm_pkg::clamp_type      in_clamp,
   input  logic [VALUE_BITS-1:0]    in_num,
   input  logic [VALUE_BITS-1:0]    in_den,
   output logic                     out_valid,
   input  logic                     out_ready,
   output stcm_pkg::clamp_type      out_clamp,
   output logic [FRACTION_BITS-1:0] out_quotient
);

   localparam int STAGES = FRACTION_BITS;

   logic                     valid_ff   [STAGES];
   stcm_pkg::clamp_type      clamp_ff   [STAGES];
   logic [VALUE_BITS-1:0]    rem_ff     [STAGES];
   logic [VALUE_BITS-1:0]    den_ff     [STAGES];
   logic [FRACTION_BITS-1:0] quot_ff    [STAGES];
   logic                     advance    [STAGES+1];

   assign advance[STAGES] = out_ready;
   assign in_ready        = advance[0];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                     prev_valid;
      stcm_pkg::clamp_type      prev_clamp;
      logic [VALUE_BITS-1:0]    prev_rem;
      logic [VALUE_BITS-1:0]    prev_den;
      logic [FRACTION_BITS-1:0] prev_quot;
      logic [VALUE_BITS:0]      doubled;
      logic                     fits;
      logic [VALUE_BITS-1:0]    rem_in;
      logic [FRACTION_BITS-1:0] quot_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_clamp = in_clamp;
         assign prev_rem   = in_num;
         assign prev_den   = in_den;
         assign prev_quot  = '0;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_clamp = clamp_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_den   = den_ff[k-1];
         assign prev_quot  = quot_ff[k-1];
      end

      // Stage k moves when empty or when stage k+1 moves.
      assign advance[k] = !valid_ff[k] || advance[k+1];

      // Double the partial remainder and subtract the divisor where it fits.
      assign doubled = {prev_rem, 1'b0};
      assign fits    = (doubled >= {1'b0, prev_den});
      assign rem_in  = fits ? VALUE_BITS'(doubled - {1'b0, prev_den})
                            : doubled[VALUE_BITS-1:0];
      assign quot_in = {prev_quot[FRACTION_BITS-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance[k]) begin
            valid_ff[k] <= prev_valid;
         end
         if (advance[k] && prev_valid) begin
            clamp_ff[k] <= prev_clamp;
            rem_ff[k]   <= rem_in;
            den_ff[k]   <= prev_den;
            quot_ff[k]  <= quot_in;
         end
      end
   end

   assign out_valid    = valid_ff[STAGES-1];
   assign out_clamp    = clamp_ff[STAGES-1];
   assign out_quotient = quot_ff[STAGES-1];

endmodule

// File: rtl/stcm_color.sv
// Color stages: map selection, scaled channel values, and rounding to 8 bits.
// Depends on stcm_pkg for map codes, palette and cool-warm constants.
module stcm_color #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [2:0]               map_kind,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  stcm_pkg::clamp_type      in_clamp,
   input  logic [FRACTION_BITS-1:0] in_quotient,
   output logic                     out_valid,
   input  logic                     out_ready,
   output stcm_pkg::rgb_type        out_color
);

   localparam int FB = FRACTION_BITS;
   localparam logic [FB:0]   ONE          = (FB+1)'(1) << FB;
   localparam logic [FB:0]   HALF         = ONE >> 1;
   localparam logic [FB+3:0] THREE_HALVES = (FB+4)'(3) << (FB-1);

   typedef struct packed {
      stcm_pkg::blend_type blend;
      logic [2:0][FB:0]    level;
      logic [3:0]          index;
      logic [FB:0]         frac;
   } stage1_type;

   typedef logic [2:0][FB+8:0] scaled_type;

   logic              valid1_ff, valid2_ff, valid3_ff;
   logic              advance1, advance2, advance3;
   stage1_type        s1_ff, s1_in;
   scaled_type        s2_ff, s2_in;
   stcm_pkg::rgb_type s3_ff, s3_in;

   logic [FB:0]       level_t;
   logic [FB+2:0]     hue6;
   logic [2:0]        sector;
   logic [FB:0]       wrap;
   logic [FB:0]       tent;
   logic [FB+4:0]     scaled15;

   // Jet ramp: 1.5 minus the distance of 4t from the center, clamped to [0,1].
   function automatic logic [FB:0] jet_ramp(input logic [FB:0] t, input logic [1:0] center);
      logic [FB+3:0] four_t;
      logic [FB+3:0] mid;
      logic [FB+3:0] distance;
      logic [FB+3:0] peak;
      logic [FB:0]   level;
      four_t   = {1'b0, t, 2'b00};
      mid      = (FB+4)'(center) << FB;
      distance = (four_t >= mid) ? (four_t - mid) : (mid - four_t);
      peak     = THREE_HALVES - distance;
      if (distance >= THREE_HALVES) begin
         level = '0;
      end else if (peak >= (FB+4)'(ONE)) begin
         level = ONE;
      end else begin
         level = peak[FB:0];
      end
      return level;
   endfunction

   // Each stage moves when empty or when the next one moves.
   assign advance3 = !valid3_ff || out_ready;
   assign advance2 = !valid2_ff || advance3;
   assign advance1 = !valid1_ff || advance2;
   assign in_ready = advance1;

   // Stage 1: resolve the fraction and pick per-map fractions or blend terms.
   always_comb begin
      level_t  = in_clamp.one ? ONE : (in_clamp.zero ? '0 : {1'b0, in_quotient});
      hue6     = {ONE - level_t, 2'b00};
      sector   = hue6[FB+2:FB];
      wrap     = hue6[FB:0];
      tent     = ONE - ((wrap >= ONE) ? (wrap - ONE) : (ONE - wrap));
      scaled15 = {level_t, 4'b0000} - (FB+5)'(level_t);
      s1_in    = '0;
      case (map_kind)
         stcm_pkg::MAP_RAINBOW: begin
            s1_in.blend = stcm_pkg::BLEND_SCALE;
            case (sector)
               3'd0: begin
                  s1_in.level[0] = ONE;
                  s1_in.level[1] = tent;
               end
               3'd1: begin
                  s1_in.level[0] = tent;
                  s1_in.level[1] = ONE;
               end
               3'd2: begin
                  s1_in.level[1] = ONE;
                  s1_in.level[2] = tent;
               end
               3'd3: begin
                  s1_in.level[1] = tent;
                  s1_in.level[2] = ONE;
               end
               3'd4: begin
                  s1_in.level[0] = tent;
                  s1_in.level[2] = ONE;
               end
               default: begin
                  s1_in.level[0] = ONE;
                  s1_in.level[2] = tent;
               end
            endcase
         end
         stcm_pkg::MAP_JET: begin
            s1_in.blend    = stcm_pkg::BLEND_SCALE;
            s1_in.level[0] = jet_ramp(level_t, 2'd3);
            s1_in.level[1] = jet_ramp(level_t, 2'd2);
            s1_in.level[2] = jet_ramp(level_t, 2'd1);
         end
         stcm_pkg::MAP_COOLWARM: begin
            if (level_t < HALF) begin
               s1_in.blend = stcm_pkg::BLEND_COOL_LOW;
               s1_in.frac  = {level_t[FB-1:0], 1'b0};
            end else begin
               s1_in.blend = stcm_pkg::BLEND_COOL_HIGH;
               s1_in.frac  = (FB+1)'({level_t, 1'b0} - {1'b0, ONE});
            end
         end
         stcm_pkg::MAP_GRAYSCALE: begin
            s1_in.blend    = stcm_pkg::BLEND_SCALE;
            s1_in.level[0] = level_t;
            s1_in.level[1] = level_t;
            s1_in.level[2] = level_t;
         end
         default: begin
            // Fringe, also for unknown codes. The very top lands on the end of
            // the last interval so that it reads the last palette entry.
            s1_in.blend = stcm_pkg::BLEND_FRINGE;
            if (scaled15[FB+4:FB] == 4'd15) begin
               s1_in.index = 4'd14;
               s1_in.frac  = ONE;
            end else begin
               s1_in.index = scaled15[FB+3:FB];
               s1_in.frac  = {1'b0, scaled15[FB-1:0]};
            end
         end
      endcase
   end

   // Stage 2: channel values scaled by 255 and by 2^FRACTION_BITS.
   always_comb begin
      stcm_pkg::rgb_type      lower;
      stcm_pkg::rgb_type      upper;
      logic [FB+8:0]          slope_term;
      logic signed [8:0]      step;
      logic signed [FB+10:0]  fringe_base;
      logic signed [FB+10:0]  fringe_prod;
      logic signed [FB+10:0]  fringe_sum;
      lower = stcm_pkg::fringe_rgb(s1_ff.index);
      upper = stcm_pkg::fringe_rgb(s1_ff.index + 4'd1);
      s2_in = '0;
      for (int k = 0; k < 3; k++) begin
         slope_term  = '0;
         step        = $signed({1'b0, upper[k]}) - $signed({1'b0, lower[k]});
         fringe_base = (FB+11)'($signed({1'b0, lower[k], {FB{1'b0}}}));
         fringe_prod = (FB+11)'($signed({1'b0, s1_ff.frac})) * (FB+11)'(step);
         fringe_sum  = fringe_base + fringe_prod;
         case (s1_ff.blend)
            stcm_pkg::BLEND_SCALE: begin
               s2_in[k] = (FB+9)'({s1_ff.level[k], 8'd0}) - (FB+9)'(s1_ff.level[k]);
            end
            stcm_pkg::BLEND_COOL_LOW: begin
               slope_term = (FB+9)'(stcm_pkg::COOL_LOW_SLOPE[k]) * (FB+9)'(s1_ff.frac);
               s2_in[k]   = (FB+9)'({stcm_pkg::COOL_BASE[k], {FB{1'b0}}}) + slope_term;
            end
            stcm_pkg::BLEND_COOL_HIGH: begin
               slope_term = (FB+9)'(stcm_pkg::COOL_HIGH_SLOPE[k]) * (FB+9)'(s1_ff.frac);
               s2_in[k]   = (FB+9)'({stcm_pkg::CHANNEL_FULL, {FB{1'b0}}}) - slope_term;
            end
            default: begin
               s2_in[k] = fringe_sum[FB+8:0];
            end
         endcase
      end
   end

   // Stage 3: round half up and saturate at full scale.
   always_comb begin
      logic [FB+8:0] rounded;
      s3_in = '0;
      for (int k = 0; k < 3; k++) begin
         rounded  = s2_ff[k] + (FB+9)'(HALF);
         s3_in[k] = rounded[FB+8] ? stcm_pkg::CHANNEL_FULL : rounded[FB+7:FB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (advance1) begin
            valid1_ff <= in_valid;
         end
         if (advance2) begin
            valid2_ff <= valid1_ff;
         end
         if (advance3) begin
            valid3_ff <= valid2_ff;
         end
      end
      if (advance1 && in_valid) begin
         s1_ff <= s1_in;
      end
      if (advance2 && valid1_ff) begin
         s2_ff <= s2_in;
      end
      if (advance3 && valid2_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = valid3_ff;
   assign out_color = s3_ff;

endmodule

// File: rtl/scalar_to_color_map.sv
// Scalar-to-color map: normalizes each signed sample against the configured range
// and colors it with one of five maps (rainbow, jet, cool-warm, grayscale, fringe).
// Takes one sample per clock while the output is not stalled, and each sample passes
// through FRACTION_BITS + 4 register stages in all (one front compare stage, one
// divider stage per fraction bit, and three color stages). The divider produces one
// quotient bit per register stage, and every stage holds its own valid bit, so stalls
// at the output fill bubbles first and the input keeps moving while any stage is
// empty. The user must write configuration through the csr_ port only while no
// sample is in flight; the block itself does not enforce this.
// Depends on stcm_pkg, stcm_ifs, stcm_front, stcm_divider and stcm_color.
module scalar_to_color_map #(
   parameter int VALUE_BITS    = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   stcm_sample_if.sink           req_chan,
   stcm_color_if.source          rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [VALUE_BITS-1:0] csr_write_data
);

   logic [VALUE_BITS-1:0]    range_low_ff;
   logic [VALUE_BITS-1:0]    range_high_ff;
   logic [2:0]               map_kind_ff;

   logic                     front_valid;
   logic                     front_ready;
   stcm_pkg::clamp_type      front_clamp;
   logic [VALUE_BITS-1:0]    front_num;
   logic [VALUE_BITS-1:0]    front_den;
   logic                     div_valid;
   logic                     div_ready;
   stcm_pkg::clamp_type      div_clamp;
   logic [FRACTION_BITS-1:0] div_quotient;
   stcm_pkg::rgb_type        color;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= VALUE_BITS'(1);
         map_kind_ff   <= stcm_pkg::MAP_FRINGE;
      end else if (csr_write_enable) begin
         case (csr_index)
            stcm_pkg::CSR_RANGE_LOW:  range_low_ff  <= csr_write_data;
            stcm_pkg::CSR_RANGE_HIGH: range_high_ff <= csr_write_data;
            stcm_pkg::CSR_MAP_KIND:   map_kind_ff   <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // Range compare and difference.
   stcm_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_sample  (req_chan.sample_value),
      .range_low  (range_low_ff),
      .range_high (range_high_ff),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_clamp  (front_clamp),
      .out_num    (front_num),
      .out_den    (front_den)
   );

   // Fraction of the range.
   stcm_divider #(
      .VALUE_BITS    (VALUE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (front_valid),
      .in_ready     (front_ready),
      .in_clamp     (front_clamp),
      .in_num       (front_num),
      .in_den       (front_den),
      .out_valid    (div_valid),
      .out_ready    (div_ready),
      .out_clamp    (div_clamp),
      .out_quotient (div_quotient)
   );

   // Color lookup and rounding; its last stage is the output register.
   stcm_color #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_color (
      .clock       (clock),
      .reset       (reset),
      .map_kind    (map_kind_ff),
      .in_valid    (div_valid),
      .in_ready    (div_ready),
      .in_clamp    (div_clamp),
      .in_quotient (div_quotient),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_color   (color)
   );

   assign rsp_chan.red   = color[0];
   assign rsp_chan.green = color[1];
   assign rsp_chan.blue  = color[2];

endmodule

// File: rtl/stcm_checker.sv
// Port-level checks for scalar_to_color_map, attached by the bind at the end.
// Depends on stcm_pkg for map codes and register indexes.
module stcm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] red,
   input logic [7:0] green,
   input logic [7:0] blue,
   input logic       csr_write_enable,
   input logic [1:0] csr_index,
   input logic [2:0] csr_map_data
);

   logic [2:0] map_ff;
   logic [7:0] pending_ff;
   logic [7:0] pending_in;

   // Track the selected map and the number of samples still owed a result.
   assign pending_in = pending_ff + 8'(req_valid && req_ready) - 8'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff     <= stcm_pkg::MAP_FRINGE;
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         if (csr_write_enable && (csr_index == stcm_pkg::CSR_MAP_KIND)) begin
            map_ff <= csr_map_data;
         end
      end
   end

   // A stalled result stays put until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(red) && $stable(green) && $stable(blue))
      else $error("result changed or dropped while stalled");

   // No result without a sample that is still owed one.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("result offered without an outstanding sample");

   // Grayscale repeats one level on all channels.
   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (map_ff == stcm_pkg::MAP_GRAYSCALE) |-> (red == green) && (green == blue))
      else $error("grayscale channels differ");

   // Rainbow runs at full value, so one channel is always at full scale.
   a_rainbow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (map_ff == stcm_pkg::MAP_RAINBOW) |->
         (red == 8'd255) || (green == 8'd255) || (blue == 8'd255))
      else $error("rainbow color without a full channel");

endmodule

bind scalar_to_color_map stcm_checker u_stcm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .red              (rsp_chan.red),
   .green            (rsp_chan.green),
   .blue             (rsp_chan.blue),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index),
   .csr_map_data     (csr_write_data[2:0])
);
